/* sv/mi_pkg.sv */
// shared types and constants for the modular inverse block
`default_nettype none

package mi_pkg;

  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WIDTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_REDUCE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic update;
    logic reduce;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic cur_zero;
    logic out_hold;
  } status_t;

endpackage

`default_nettype wire

/* sv/mi_ctrl.sv */
// sequencer for the euclid loop and the bit-serial divider
`default_nettype none

module mi_ctrl
  import mi_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.cur_zero) begin
          state_d = ST_REDUCE;
        end else begin
          cmd_o.div_init = 1'b1;
          cnt_d          = CNT_LAST;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_UPDATE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_CHECK;
      end
      ST_REDUCE: begin
        cmd_o.reduce = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status_i.out_hold) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/mi_dp.sv */
// euclid datapath: remainders, coefficients, shift-subtract divider, output register
`default_nettype none

module mi_dp
  import mi_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cmd_t             cmd_i,
  output status_t               status_o,
  input  wire logic             cfg_valid_i,
  input  wire logic [WIDTH-1:0] cfg_data_i,
  input  wire logic [WIDTH-1:0] value_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [WIDTH-1:0]      inverse_o,
  output logic [WIDTH-1:0]      common_divisor_o
);

  logic [WIDTH-1:0] mod_q;
  logic [WIDTH-1:0] prev_r_q, cur_r_q, prev_m_q, cur_m_q;
  logic             odd_q;
  logic [WIDTH-1:0] rem_q, dvd_q, t_q;
  logic             out_valid_q;
  logic [WIDTH-1:0] inverse_q, cd_q;

  logic [WIDTH:0]   trial;
  logic [WIDTH:0]   trial_sub;
  logic             trial_ge;
  logic [WIDTH-1:0] m_red;
  logic [WIDTH-1:0] inv_final;

  // one restoring division step, quotient bits folded into q * cur_m
  assign trial     = {rem_q, dvd_q[WIDTH-1]};
  assign trial_sub = trial - {1'b0, cur_r_q};
  assign trial_ge  = trial >= {1'b0, cur_r_q};

  // coefficient magnitude stays below twice the modulus
  assign m_red     = (prev_m_q >= mod_q) ? (prev_m_q - mod_q) : prev_m_q;

  always_comb begin
    if (mod_q == '0) begin
      inv_final = '0;
    end else if (odd_q && (prev_m_q != '0)) begin
      inv_final = mod_q - prev_m_q;
    end else begin
      inv_final = prev_m_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q       <= WIDTH'(1);
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mod_q <= cfg_data_i;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      prev_r_q <= value_i;
      cur_r_q  <= mod_q;
      prev_m_q <= WIDTH'(1);
      cur_m_q  <= '0;
      odd_q    <= 1'b0;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      dvd_q <= prev_r_q;
      t_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= trial_ge ? trial_sub[WIDTH-1:0] : trial[WIDTH-1:0];
      dvd_q <= {dvd_q[WIDTH-2:0], 1'b0};
      t_q   <= {t_q[WIDTH-2:0], 1'b0} + (trial_ge ? cur_m_q : '0);
    end
    if (cmd_i.update) begin
      prev_r_q <= cur_r_q;
      cur_r_q  <= rem_q;
      prev_m_q <= cur_m_q;
      cur_m_q  <= prev_m_q + t_q;
      odd_q    <= ~odd_q;
    end
    if (cmd_i.reduce) begin
      prev_m_q <= m_red;
    end
    if (cmd_i.emit) begin
      inverse_q <= inv_final;
      cd_q      <= prev_r_q;
    end
  end

  assign status_o.cur_zero = (cur_r_q == '0);
  assign status_o.out_hold = out_valid_q && out_stall_i;

  assign out_valid_o      = out_valid_q;
  assign inverse_o        = inverse_q;
  assign common_divisor_o = cd_q;

endmodule

`default_nettype wire

/* sv/modular_inverse_top.sv */
// modular inverse by extended euclid: top level joining sequencer and datapath
// the number of euclid steps is at most about 1.44*WIDTH; each step runs one shift-subtract divide
// one transaction in flight; the next is taken while a result waits in the output register
// reset: asynchronous active low, modulus returns to 1, no result pending
`default_nettype none

module modular_inverse_top
  import mi_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // configuration: modulus write, always ready
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [WIDTH-1:0] cfg_data_i,
  // input transactions
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [WIDTH-1:0] value_i,
  // result transactions
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [WIDTH-1:0]      inverse_o,
  output logic [WIDTH-1:0]      common_divisor_o
);

  cmd_t    cmd;
  status_t status;

  // modulus register accepts a write every cycle
  assign cfg_ready_o = 1'b1;

  // sequencer: load, per-step divide and coefficient update, final reduction, emit
  mi_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath with the modulus register and the result register
  mi_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .inverse_o        (inverse_o),
    .common_divisor_o (common_divisor_o)
  );

endmodule

`default_nettype wire

/* tb/tb_modular_inverse_top.sv */
// self-checking testbench for the modular inverse block
`default_nettype none

module tb_modular_inverse_top;
  import mi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [WIDTH-1:0] word_t;

  // one expected result, kept with the operands that produced it
  typedef struct {
    word_t value;
    word_t modulus;
    word_t inverse;
    word_t common_divisor;
  } inv_expect_t;

  // worst case latency of a single transaction: every euclid step a full divide
  localparam int unsigned MAX_LATENCY = 4 + (2 * WIDTH + 4) * (WIDTH + 2);
  localparam int unsigned RANDOM_BATCHES = 7;
  localparam int unsigned BATCH_ITEMS = 60;
  localparam int unsigned HOLD_CYCLES = 1200;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  cfg_valid_i = 1'b0;
  logic  cfg_ready_o;
  word_t cfg_data_i = '0;
  logic  in_valid_i = 1'b0;
  logic  in_stall_o;
  word_t value_i = '0;
  logic  out_valid_o;
  logic  out_stall_i = 1'b0;
  word_t inverse_o;
  word_t common_divisor_o;

  // predictor copy of the modulus register, reset value 1
  word_t       modulus_shadow = word_t'(1);
  inv_expect_t inverse_q[$];
  int unsigned fail_count = 0;

  // idling controls, percent per decision
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  // long receiver hold-off, counts down in its own process
  int unsigned hold_left = 0;

  modular_inverse_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .value_i          (value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .inverse_o        (inverse_o),
    .common_divisor_o (common_divisor_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // extended euclid on double width so the coefficient products never wrap
  function automatic inv_expect_t predict_inverse(input word_t modulus, input word_t value);
    logic [2*WIDTH-1:0] rem_prev, rem_cur, coef_prev, coef_cur, quo, rem_next, coef_next;
    logic               odd;
    int                 steps;
    inv_expect_t        res;
    res.value = value;
    res.modulus = modulus;
    if (modulus == '0) begin
      res.inverse = '0;
      res.common_divisor = value;
      return res;
    end
    rem_prev = value;
    rem_cur = modulus;
    coef_prev = 1;
    coef_cur = 0;
    odd = 1'b0;
    // coefficient magnitudes only, the sign flips every step
    for (steps = 0; steps < 2 * WIDTH + 4 && rem_cur != 0; steps++) begin
      quo = rem_prev / rem_cur;
      rem_next = rem_prev - quo * rem_cur;
      coef_next = coef_prev + quo * coef_cur;
      rem_prev = rem_cur;
      rem_cur = rem_next;
      coef_prev = coef_cur;
      coef_cur = coef_next;
      odd = ~odd;
    end
    coef_prev = coef_prev % modulus;
    // negative coefficient folds back into 0 .. modulus-1
    if (odd && coef_prev != 0) coef_prev = modulus - coef_prev;
    res.inverse = coef_prev[WIDTH-1:0];
    res.common_divisor = rem_prev[WIDTH-1:0];
    return res;
  endfunction

  // receiver: random stall, forced high during a hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result checker: every accepted transaction against the oldest expectation
  always @(posedge clk_i) begin
    inv_expect_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual inverse %h gcd %h",
                 $time, inverse_o, common_divisor_o);
        fail_count++;
      end else begin
        exp_res = inverse_q.pop_front();
        if (inverse_o !== exp_res.inverse) begin
          $display("%0t: inverse of %h mod %h: expected %h actual %h", $time,
                   exp_res.value, exp_res.modulus, exp_res.inverse, inverse_o);
          fail_count++;
        end
        if (common_divisor_o !== exp_res.common_divisor) begin
          $display("%0t: gcd of %h and %h: expected %h actual %h", $time,
                   exp_res.value, exp_res.modulus, exp_res.common_divisor, common_divisor_o);
          fail_count++;
        end
      end
    end
  end

  // one input transaction, with an optional idle gap in front of it
  task automatic send_value(input word_t value);
    int unsigned gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      // long enough gaps to land anywhere inside a divide
      gap = $urandom_range(1, 2 * WIDTH + 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i <= value;
    do @(posedge clk_i); while (in_stall_o);
    inverse_q.push_back(predict_inverse(modulus_shadow, value));
  endtask

  // stop sending and let every pending result come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_modulus(input word_t modulus);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= modulus;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    modulus_shadow = modulus;
  endtask

  function automatic word_t pick_modulus(input int unsigned kind);
    word_t m;
    case (kind % 4)
      0: m = word_t'($urandom_range(1, 255));
      1: m = word_t'($urandom_range(256, 65535));
      2: m = word_t'($urandom);
      default: m = '1 - word_t'($urandom_range(0, 1000));
    endcase
    if (m == '0) m = word_t'(1);
    return m;
  endfunction

  function automatic word_t pick_value(input word_t modulus);
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel <= 5) return word_t'($urandom);
    if (sel <= 7) return word_t'($urandom) % modulus;
    case ($urandom_range(5))
      0: return '0;
      1: return word_t'(1);
      2: return modulus - 1;
      3: return modulus;
      4: return modulus + 1;
      default: return '1;
    endcase
  endfunction

  // modulus still at its reset value of one
  task automatic test_reset_modulus();
    send_value('0);
    send_value(word_t'(1));
    send_value('1);
    drain_results();
  endtask

  // field extremes, zero value, value at or above the modulus, shared factors
  task automatic test_directed_extremes();
    write_modulus('1);
    send_value('0);
    send_value(word_t'(1));
    send_value(word_t'(2));
    send_value(word_t'(3));
    send_value('1 - 1);
    send_value('1);
    send_value(word_t'(1) << (WIDTH - 1));
    drain_results();
    write_modulus(word_t'(2));
    send_value('0);
    send_value(word_t'(1));
    send_value(word_t'(2));
    send_value(word_t'(3));
    drain_results();
    write_modulus('1 - 4);
    send_value(word_t'(2));
    send_value('1 - 5);
    drain_results();
    write_modulus(word_t'(1) << (WIDTH - 1));
    send_value(word_t'(32'h5555_5555));
    send_value('1 >> 1);
    drain_results();
  endtask

  // consecutive fibonacci numbers give the longest euclid chain
  task automatic test_worst_case_chain();
    write_modulus(word_t'(32'hB119_24E1));
    send_value(word_t'(32'h6D73_E55F));
    send_value(word_t'(32'hB119_24E1) - word_t'(32'h6D73_E55F));
    drain_results();
  endtask

  // receiver holds off while the sender keeps offering, block must stall input
  task automatic test_full_backpressure();
    int unsigned i;
    send_idle_pct = 0;
    stall_pct = 0;
    write_modulus(word_t'(97));
    hold_left <= HOLD_CYCLES;
    for (i = 0; i < 12; i++) send_value(pick_value(word_t'(97)));
    drain_results();
  endtask

  // random batches, one modulus per batch, under each idling profile
  task automatic test_random_traffic();
    int unsigned profile, batch, i;
    for (profile = 0; profile < 4; profile++) begin
      case (profile)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 64; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 64; end
        default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      for (batch = 0; batch < RANDOM_BATCHES; batch++) begin
        write_modulus(pick_modulus(batch + profile));
        for (i = 0; i < BATCH_ITEMS; i++) send_value(pick_value(modulus_shadow));
        drain_results();
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_modulus();
    test_directed_extremes();
    test_worst_case_chain();
    test_full_backpressure();
    test_random_traffic();

    // quiet period: nothing more may come out
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (MAX_LATENCY) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #(40_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
